// File: rtl/fstt_pkg.sv
// ----------------------------------------------------------------------------
// fstt_pkg
// Shared types and constants of the format string to text formatter.
// ----------------------------------------------------------------------------
package fstt_pkg;

  // Fill is emitted only when the remaining count is at most PadLimit - 2.
  localparam int unsigned PadLimit = 16;
  localparam logic [7:0]  PadMax   = 8'(PadLimit - 2);

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChLf      = 8'h0a;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChSpace   = 8'h20;

  // Conversion specifier characters.
  localparam logic [7:0] ChSpecC   = 8'h63;
  localparam logic [7:0] ChSpecD   = 8'h64;
  localparam logic [7:0] ChSpecI   = 8'h69;
  localparam logic [7:0] ChSpecU   = 8'h75;
  localparam logic [7:0] ChSpecX   = 8'h78;
  localparam logic [7:0] ChSpecUpX = 8'h58;
  localparam logic [7:0] ChSpecP   = 8'h70;

  // Number conversion control from the parser to the digit unit.
  typedef struct packed {
    logic        hex;
    logic        neg;
    logic        zero_fill;
    logic [7:0]  width;
    logic [31:0] mag;
  } num_cmd_t;

  // Map a digit value to its lowercase ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = ChZero + {4'd0, d};
    else           c = 8'h57 + {4'd0, d};
    return c;
  endfunction

  // ERROR text, one letter per index.
  function automatic logic [7:0] err_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h45;
      3'd1:    c = 8'h52;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4f;
      default: c = 8'h52;
    endcase
    return c;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEXT,
    ST_ERR,
    ST_DIV,
    ST_SIGN0,
    ST_PAD,
    ST_SIGN1,
    ST_DIGITS
  } state_e;

endpackage

// File: rtl/fstt_divider.sv
// ----------------------------------------------------------------------------
// fstt_divider
// Bit-serial divide by ten: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fstt_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [3:0]  rem_o
);

  logic [31:0] quot_q, quot_d;
  logic [4:0]  rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [4:0]  trial;
  logic [31:0] step_quot;
  logic [4:0]  step_rem;

  // Restoring division step on a five-bit partial remainder.
  always_comb begin
    trial = {rem_q[3:0], quot_q[31]};
    if (trial >= 5'd10) begin
      step_rem  = trial - 5'd10;
      step_quot = {quot_q[30:0], 1'b1};
    end else begin
      step_rem  = trial;
      step_quot = {quot_q[30:0], 1'b0};
    end
  end

  // A new start takes priority over the running step.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = 5'd0;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = step_quot;
      rem_d  = step_rem;
      cnt_d  = cnt_q + 6'd1;
      if (cnt_q == 6'd31) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  // Results of the last step, valid while done is high.
  assign done_o = busy_q && (cnt_q == 6'd31);
  assign quot_o = step_quot;
  assign rem_o  = step_rem[3:0];

endmodule

// File: rtl/fstt_number.sv
// ----------------------------------------------------------------------------
// fstt_number
// Converts a magnitude to digits, stores them, and emits sign, fill and digits.
// ----------------------------------------------------------------------------
module fstt_number (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  fstt_pkg::num_cmd_t cmd_i,
  output logic             busy_o,
  output logic             out_valid_o,
  output logic [7:0]       out_char_o,
  output logic             out_last_o,
  input  logic             out_take_i
);

  fstt_pkg::state_e state_q, state_d;
  fstt_pkg::num_cmd_t cmd_q;
  logic [31:0] mag_q, mag_d;
  logic [3:0]  digs_q [10];
  logic [3:0]  nd_q, nd_d;
  logic [7:0]  pad_q, pad_d;
  logic        div_start, div_done;
  logic [31:0] div_quot;
  logic [3:0]  div_rem;
  logic [8:0]  rem_w;
  logic        store;

  fstt_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(mag_d),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // Remaining fill count from width, digit count and sign.
  assign rem_w = {1'b0, cmd_q.width} - {5'd0, nd_q} - {8'd0, cmd_q.neg};

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    nd_d        = nd_q;
    pad_d       = pad_q;
    div_start   = 1'b0;
    store       = 1'b0;
    out_valid_o = 1'b0;
    out_char_o  = fstt_pkg::ChZero;
    out_last_o  = 1'b0;
    case (state_q)
      fstt_pkg::ST_IDLE: begin
        if (start_i) begin
          mag_d = cmd_i.mag;
          nd_d  = 4'd0;
          if (cmd_i.hex) begin
            state_d = fstt_pkg::ST_DIV;
          end else begin
            div_start = 1'b1;
            state_d   = fstt_pkg::ST_DIV;
          end
        end
      end
      fstt_pkg::ST_DIV: begin
        // Hex takes one nibble per cycle, decimal waits for the divider.
        if (cmd_q.hex) begin
          store = 1'b1;
          mag_d = {4'd0, mag_q[31:4]};
          nd_d  = nd_q + 4'd1;
          if (mag_q[31:4] == 28'd0) state_d = fstt_pkg::ST_SIGN0;
        end else if (div_done) begin
          store = 1'b1;
          mag_d = div_quot;
          nd_d  = nd_q + 4'd1;
          if (div_quot == 32'd0) state_d = fstt_pkg::ST_SIGN0;
          else div_start = 1'b1;
        end
      end
      fstt_pkg::ST_SIGN0: begin
        pad_d = (!rem_w[8] && rem_w != 9'd0 && rem_w[7:0] <= fstt_pkg::PadMax) ?
                rem_w[7:0] : 8'd0;
        if (cmd_q.neg && cmd_q.zero_fill) begin
          out_valid_o = 1'b1;
          out_char_o  = fstt_pkg::ChMinus;
          if (out_take_i) state_d = fstt_pkg::ST_PAD;
        end else begin
          state_d = fstt_pkg::ST_PAD;
        end
      end
      fstt_pkg::ST_PAD: begin
        if (pad_q == 8'd0) begin
          state_d = fstt_pkg::ST_SIGN1;
        end else begin
          out_valid_o = 1'b1;
          out_char_o  = cmd_q.zero_fill ? fstt_pkg::ChZero : fstt_pkg::ChSpace;
          if (out_take_i) pad_d = pad_q - 8'd1;
        end
      end
      fstt_pkg::ST_SIGN1: begin
        if (cmd_q.neg && !cmd_q.zero_fill) begin
          out_valid_o = 1'b1;
          out_char_o  = fstt_pkg::ChMinus;
          if (out_take_i) state_d = fstt_pkg::ST_DIGITS;
        end else begin
          state_d = fstt_pkg::ST_DIGITS;
        end
      end
      fstt_pkg::ST_DIGITS: begin
        out_valid_o = 1'b1;
        out_char_o  = fstt_pkg::digit_char(digs_q[nd_q - 4'd1]);
        out_last_o  = (nd_q == 4'd1);
        if (out_take_i) begin
          nd_d = nd_q - 4'd1;
          if (nd_q == 4'd1) state_d = fstt_pkg::ST_IDLE;
        end
      end
      default: state_d = fstt_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != fstt_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fstt_pkg::ST_IDLE;
      nd_q    <= 4'd0;
      pad_q   <= 8'd0;
    end else begin
      state_q <= state_d;
      nd_q    <= nd_d;
      pad_q   <= pad_d;
    end
  end

  // Digit store, least significant digit first.
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    if (start_i && state_q == fstt_pkg::ST_IDLE) cmd_q <= cmd_i;
    if (store) digs_q[nd_q] <= cmd_q.hex ? mag_q[3:0] : div_rem;
  end

endmodule

// File: rtl/format_string_to_text.sv
// ----------------------------------------------------------------------------
// format_string_to_text
// Printf-style formatter: one format character in, zero or more characters out.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// fmt     | in        | fmt_char_i, arg_value_i (valid/stall)
// out     | out       | out_char_o, last_o, arg_used_o (valid/stall)
// A decimal conversion runs the bit-serial divider once per digit; hex takes
// one nibble per digit. Both then step through the sign and fill steps before
// emitting the digits, one character per output item.
// Reset clears the parser state; the output register holds any stalled item.
// Input is taken only when the previous item has emitted all its characters.
// ----------------------------------------------------------------------------
module format_string_to_text (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fmt_valid_i,
  output logic        fmt_stall_o,
  input  logic [7:0]  fmt_char_i,
  input  logic [31:0] arg_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        last_o,
  output logic        arg_used_o
);

  fstt_pkg::state_e   state_q, state_d;
  logic               pct_q, pct_d;
  logic [7:0]         width_q, width_d;
  logic               zf_q, zf_d;
  logic [7:0]         ch_q;
  logic               used_q, used_d;
  logic               cr_q, cr_d;
  logic [2:0]         eidx_q, eidx_d;
  logic               accept;
  logic               num_start, num_busy, num_valid, num_last;
  logic [7:0]         num_char;
  fstt_pkg::num_cmd_t num_cmd;
  logic [11:0]        wmul;

  // Output register.
  logic       ov_q;
  logic [7:0] oc_q;
  logic       ol_q, ou_q;
  logic       slot_free;
  logic       emit;
  logic [7:0] emit_char;
  logic       emit_last;

  assign slot_free = !ov_q || !out_stall_i;
  assign fmt_stall_o = (state_q != fstt_pkg::ST_IDLE);
  assign accept = fmt_valid_i && !fmt_stall_o;
  assign wmul = {1'b0, width_q, 3'd0} + {3'd0, width_q, 1'b0} +
                {4'd0, fmt_char_i - fstt_pkg::ChZero};

  fstt_number u_num (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (num_start),
    .cmd_i      (num_cmd),
    .busy_o     (num_busy),
    .out_valid_o(num_valid),
    .out_char_o (num_char),
    .out_last_o (num_last),
    .out_take_i (slot_free && state_q == fstt_pkg::ST_DIV)
  );

  // Parser: decodes each item, starts number conversions and sequences text, ERROR and number output.
  always_comb begin
    state_d   = state_q;
    pct_d     = pct_q;
    width_d   = width_q;
    zf_d      = zf_q;
    used_d    = used_q;
    cr_d      = cr_q;
    eidx_d    = eidx_q;
    num_start = 1'b0;
    num_cmd.hex       = 1'b0;
    num_cmd.neg       = 1'b0;
    num_cmd.zero_fill = zf_q;
    num_cmd.width     = width_q;
    num_cmd.mag       = arg_value_i;
    emit      = 1'b0;
    emit_char = ch_q;
    emit_last = 1'b0;
    case (state_q)
      fstt_pkg::ST_IDLE: begin
        if (accept) begin
          cr_d = (fmt_char_i == fstt_pkg::ChLf);
          if (!pct_q) begin
            if (fmt_char_i == fstt_pkg::ChPercent) begin
              pct_d = 1'b1; width_d = 8'd0; zf_d = 1'b0;
            end else if (fmt_char_i != fstt_pkg::ChNul) begin
              used_d = 1'b0; state_d = fstt_pkg::ST_TEXT;
            end
          end else if (fmt_char_i >= fstt_pkg::ChZero && fmt_char_i <= fstt_pkg::ChNine) begin
            if (fmt_char_i == fstt_pkg::ChZero && width_q == 8'd0) zf_d = 1'b1;
            width_d = (wmul > 12'd255) ? 8'd255 : wmul[7:0];
          end else begin
            pct_d = 1'b0; width_d = 8'd0; zf_d = 1'b0;
            case (fmt_char_i)
              fstt_pkg::ChSpecC: begin
                used_d = 1'b1; cr_d = (arg_value_i[7:0] == fstt_pkg::ChLf);
                state_d = fstt_pkg::ST_TEXT;
              end
              fstt_pkg::ChSpecD, fstt_pkg::ChSpecI: begin
                num_start = 1'b1; used_d = 1'b1; state_d = fstt_pkg::ST_DIV;
                num_cmd.neg = arg_value_i[31];
                num_cmd.mag = arg_value_i[31] ? (32'd0 - arg_value_i) : arg_value_i;
              end
              fstt_pkg::ChSpecU: begin
                num_start = 1'b1; used_d = 1'b1; state_d = fstt_pkg::ST_DIV;
              end
              fstt_pkg::ChSpecX, fstt_pkg::ChSpecUpX, fstt_pkg::ChSpecP: begin
                num_start = 1'b1; used_d = 1'b1; state_d = fstt_pkg::ST_DIV;
                num_cmd.hex = 1'b1;
              end
              fstt_pkg::ChPercent: begin
                used_d = 1'b0; cr_d = 1'b0; state_d = fstt_pkg::ST_TEXT;
              end
              default: begin
                used_d = 1'b0; eidx_d = 3'd0; state_d = fstt_pkg::ST_ERR;
              end
            endcase
          end
        end
      end
      fstt_pkg::ST_TEXT: begin
        emit      = 1'b1;
        emit_char = cr_q ? fstt_pkg::ChCr : ch_q;
        emit_last = !cr_q;
        if (slot_free) begin
          if (cr_q) cr_d = 1'b0;
          else state_d = fstt_pkg::ST_IDLE;
        end
      end
      fstt_pkg::ST_ERR: begin
        emit      = 1'b1;
        emit_char = fstt_pkg::err_char(eidx_q);
        emit_last = (eidx_q == 3'd4);
        if (slot_free) begin
          eidx_d = eidx_q + 3'd1;
          if (eidx_q == 3'd4) state_d = fstt_pkg::ST_IDLE;
        end
      end
      fstt_pkg::ST_DIV: begin
        emit      = num_valid;
        emit_char = num_char;
        emit_last = num_last;
        if (num_valid && num_last && slot_free) state_d = fstt_pkg::ST_IDLE;
      end
      default: state_d = fstt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fstt_pkg::ST_IDLE;
      pct_q   <= 1'b0;
      width_q <= 8'd0;
      zf_q    <= 1'b0;
      used_q  <= 1'b0;
      cr_q    <= 1'b0;
      eidx_q  <= 3'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pct_q   <= pct_d;
      width_q <= width_d;
      zf_q    <= zf_d;
      used_q  <= used_d;
      cr_q    <= cr_d;
      eidx_q  <= eidx_d;
      if (slot_free) ov_q <= emit;
    end
  end

  // Character latch and output payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q <= (fmt_char_i == fstt_pkg::ChSpecC && pct_q) ? arg_value_i[7:0] :
              fmt_char_i;
    end
    if (slot_free && emit) begin
      oc_q <= emit_char;
      ol_q <= emit_last;
      ou_q <= used_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = oc_q;
  assign last_o      = ol_q;
  assign arg_used_o  = ou_q;

  // A stalled output item holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o))
    else $error("stalled output changed");

  // No input is taken while the number unit is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_busy |-> !accept)
    else $error("input accepted during conversion");

  // The number unit only starts from idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_start |-> !num_busy)
    else $error("number unit restarted while busy");

endmodule

// File: sim/format_string_to_text_tb.sv
// ----------------------------------------------------------------------------
// format_string_to_text_tb
// Drives format characters and argument words into the formatter, predicts
// the emitted text characters, and compares every output item in order.
// ----------------------------------------------------------------------------
module format_string_to_text_tb;

  // Emitted character with its flags.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       used;
  } text_item_t;

  // One directed row; has_exp marks rows whose text is typed in.
  typedef struct {
    logic [7:0]  ch;
    logic [31:0] arg;
    bit          has_exp;
    string       exp_text;
    bit          exp_used;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        fmt_valid_i = 1'b0;
  logic        fmt_stall_o;
  logic [7:0]  fmt_char_i = '0;
  logic [31:0] arg_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_char_o;
  logic        last_o;
  logic        arg_used_o;

  text_item_t  expected_text[$];
  int          errors = 0;
  bit          hold_long = 1'b0;
  bit          stim_done = 1'b0;

  // Predictor state.
  bit          in_spec;
  logic [7:0]  spec_width;
  bit          spec_zero;

  format_string_to_text DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  initial begin
    #80_000_000;
    $display("format_string_to_text_tb: done, errors");
    $finish;
  end

  function automatic void push_char(inout text_item_t q[$], input logic [7:0] c,
                                    input bit used);
    q.push_back('{c, 1'b0, used});
  endfunction

  function automatic void push_text_char(inout text_item_t q[$],
                                         input logic [7:0] c, input bit used);
    if (c == fstt_pkg::ChLf) push_char(q, fstt_pkg::ChCr, used);
    push_char(q, c, used);
  endfunction

  // Number with sign and optional fill.
  function automatic void push_number(inout text_item_t q[$], input logic [31:0] mag,
                                      input bit hex, input bit neg,
                                      input logic [7:0] width, input bit zf);
    logic [7:0] digs[$];
    int         pad;
    do begin
      digs.push_front(fstt_pkg::digit_char(hex ? mag[3:0] : 4'(mag % 10)));
      mag = hex ? mag >> 4 : mag / 10;
    end while (mag != 0);
    pad = int'(width) - digs.size() - (neg ? 1 : 0);
    if (neg && zf) push_char(q, fstt_pkg::ChMinus, 1'b1);
    if (pad >= 1 && pad <= int'(fstt_pkg::PadMax))
      repeat (pad) push_char(q, zf ? fstt_pkg::ChZero : fstt_pkg::ChSpace, 1'b1);
    if (neg && !zf) push_char(q, fstt_pkg::ChMinus, 1'b1);
    foreach (digs[i]) push_char(q, digs[i], 1'b1);
  endfunction

  // Work out the text caused by one format character.
  function automatic void format_step(input logic [7:0] c, input logic [31:0] a,
                                      output text_item_t q[$]);
    int nw;
    q = {};
    if (!in_spec) begin
      if (c == fstt_pkg::ChPercent) begin
        in_spec = 1; spec_width = 0; spec_zero = 0;
      end else if (c != fstt_pkg::ChNul) begin
        push_text_char(q, c, 1'b0);
      end
    end else if (c >= fstt_pkg::ChZero && c <= fstt_pkg::ChNine) begin
      if (c == fstt_pkg::ChZero && spec_width == 0) spec_zero = 1;
      nw = int'(spec_width) * 10 + int'(c - fstt_pkg::ChZero);
      spec_width = nw > 255 ? 8'd255 : 8'(nw);
    end else begin
      case (c)
        fstt_pkg::ChSpecC: push_text_char(q, a[7:0], 1'b1);
        fstt_pkg::ChSpecD, fstt_pkg::ChSpecI:
          if (a[31]) push_number(q, -a, 0, 1, spec_width, spec_zero);
          else       push_number(q, a, 0, 0, spec_width, spec_zero);
        fstt_pkg::ChSpecU: push_number(q, a, 0, 0, spec_width, spec_zero);
        fstt_pkg::ChSpecX, fstt_pkg::ChSpecUpX, fstt_pkg::ChSpecP:
          push_number(q, a, 1, 0, spec_width, spec_zero);
        fstt_pkg::ChPercent: push_char(q, fstt_pkg::ChPercent, 1'b0);
        default: begin
          string e = "ERROR";
          foreach (e[i]) push_char(q, e[i], 1'b0);
        end
      endcase
      in_spec = 0; spec_width = 0; spec_zero = 0;
    end
    if (q.size() > 0) q[q.size()-1].last = 1'b1;
  endfunction

  // Offer one item after a random gap, and queue its expected text.
  task automatic offer_item(input logic [7:0] c, input logic [31:0] a);
    text_item_t q[$];
    repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15)) @(negedge clk_i);
    fmt_char_i = c;
    arg_value_i = a;
    fmt_valid_i = 1'b1;
    do @(posedge clk_i); while (fmt_stall_o);
    format_step(c, a, q);
    foreach (q[i]) expected_text.push_back(q[i]);
    @(negedge clk_i);
    fmt_valid_i = 1'b0;
  endtask

  task automatic drain_text();
    while (expected_text.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_spec();
    case ($urandom_range(0, 9))
      0: return fstt_pkg::ChSpecC;
      1: return fstt_pkg::ChSpecD;
      2: return fstt_pkg::ChSpecI;
      3: return fstt_pkg::ChSpecU;
      4: return fstt_pkg::ChSpecX;
      5: return fstt_pkg::ChSpecUpX;
      6: return fstt_pkg::ChSpecP;
      7: return fstt_pkg::ChPercent;
      8: return "s";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 99));
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff - 32'($urandom_range(0, 50));
      default: return $urandom();
    endcase
  endfunction

  // Stimulus.
  initial begin
    row_t rows[$];
    text_item_t q[$];
    int n;
    int w;
    rows = '{
      '{"A", 0, 1, "A", 0},
      '{fstt_pkg::ChLf, 0, 1, "\r\n", 0},
      '{fstt_pkg::ChNul, 0, 1, "", 0},
      '{8'hff, 0, 1, "\377", 0},
      '{fstt_pkg::ChPercent, 0, 1, "", 0},
      '{"d", 32'h8000_0000, 1, "-2147483648", 1},
      '{fstt_pkg::ChPercent, 0, 1, "", 0},
      '{"0", 0, 1, "", 0},
      '{"8", 0, 1, "", 0},
      '{"x", 32'hff, 1, "000000ff", 1},
      '{fstt_pkg::ChPercent, 0, 0, "", 0},
      '{"5", 0, 0, "", 0},
      '{"i", 32'hffff_fff6, 0, "", 0},
      '{fstt_pkg::ChPercent, 0, 1, "", 0},
      '{"c", 32'h0a, 1, "\r\n", 1},
      '{fstt_pkg::ChPercent, 0, 1, "", 0},
      '{"u", 32'hffff_ffff, 1, "4294967295", 1},
      '{fstt_pkg::ChPercent, 0, 1, "", 0},
      '{fstt_pkg::ChPercent, 32'hffff_ffff, 1, "%", 0},
      '{fstt_pkg::ChPercent, 0, 1, "", 0},
      '{"s", 0, 1, "ERROR", 0},
      '{fstt_pkg::ChPercent, 0, 1, "", 0},
      '{fstt_pkg::ChNul, 0, 1, "ERROR", 0},
      '{fstt_pkg::ChPercent, 0, 0, "", 0},
      '{"X", 32'hdead_beef, 0, "", 0}
    };
    in_spec = 0; spec_width = 0; spec_zero = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table.
    foreach (rows[r]) begin
      offer_item(rows[r].ch, rows[r].arg);
      if (rows[r].has_exp) begin
        n = expected_text.size() - rows[r].exp_text.len();
        if (n < 0) begin
          $error("row %0d text length: expected %0d, got %0d", r,
                 rows[r].exp_text.len(), expected_text.size());
          errors++;
        end else begin
          for (int i = 0; i < rows[r].exp_text.len(); i++) begin
            if (expected_text[n+i].ch != rows[r].exp_text[i]) begin
              $error("row %0d out_char: expected %h, got %h", r,
                     rows[r].exp_text[i], expected_text[n+i].ch);
              errors++;
            end
            if (expected_text[n+i].used != rows[r].exp_used) begin
              $error("row %0d arg_used: expected %b, got %b", r,
                     rows[r].exp_used, expected_text[n+i].used);
              errors++;
            end
          end
        end
      end
    end

    // Sender pauses until all text has come out.
    drain_text();

    // Long receiver hold-off while items keep coming.
    hold_long = 1'b1;
    for (int k = 0; k < 10; k++) begin
      offer_item(fstt_pkg::ChPercent, 0);
      offer_item(fstt_pkg::ChSpecX, $urandom());
    end

    // Random part: mostly well-formed conversions, some noise.
    for (int k = 0; k < 85; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        offer_item(8'($urandom_range(0, 255)), $urandom());
      end else begin
        offer_item(fstt_pkg::ChPercent, $urandom());
        w = $urandom_range(0, 4);
        if ($urandom_range(0, 1)) begin
          offer_item(fstt_pkg::ChZero, $urandom()); w--;
        end
        for (int j = 0; j < w; j++)
          offer_item(fstt_pkg::ChZero + 8'($urandom_range(0, 9)), $urandom());
        offer_item(pick_spec(), pick_arg());
      end
    end
    drain_text();
    repeat (400) @(negedge clk_i);
    stim_done = 1'b1;
  end

  // Receiver stall: random, with one long hold-off.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i = 1'b1;
        repeat (3000) @(negedge clk_i);
        hold_long = 1'b0;
        out_stall_i = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // Output checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      text_item_t e;
      if (expected_text.size() == 0) begin
        $error("unexpected output item: char %h", out_char_o);
        errors++;
      end else begin
        e = expected_text.pop_front();
        if (out_char_o !== e.ch) begin
          $error("out_char: expected %h, got %h", e.ch, out_char_o);
          errors++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %b, got %b", e.last, last_o);
          errors++;
        end
        if (arg_used_o !== e.used) begin
          $error("arg_used: expected %b, got %b", e.used, arg_used_o);
          errors++;
        end
      end
    end
  end

  // Final verdict.
  initial begin
    wait (stim_done);
    if (errors == 0 && expected_text.size() == 0)
      $display("format_string_to_text_tb: done, clean");
    else
      $display("format_string_to_text_tb: done, errors");
    $finish;
  end
endmodule
